// File: src/wnrs_pkg.sv
// wnrs_pkg: shared types and codes for the wind noise role switch judge
// request payload structs, action codes and the sequencer state type
// no dependencies
package wnrs_pkg;

  localparam logic [1:0] ACT_SAMPLE = 2'd0;
  localparam logic [1:0] ACT_PEER   = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;

  localparam int LEVEL_W = 16;
  localparam logic signed [LEVEL_W-1:0] GAP_LIMIT_RST = 16'sd10;
  localparam logic signed [LEVEL_W-1:0] LEVEL_MAX     = 16'sh7FFF;
  localparam logic signed [LEVEL_W-1:0] LEVEL_MIN     = 16'sh8000;

  typedef struct packed {
    logic [1:0]                action;
    logic                      call_mode;
    logic                      local_wind_flag;
    logic signed [LEVEL_W-1:0] local_wind_value;
    logic                      peer_length_ok;
    logic                      peer_run;
    logic                      peer_wind_flag;
    logic signed [LEVEL_W-1:0] peer_wind_level;
    logic                      links_up;
    logic                      both_in_ear;
    logic                      is_primary;
  } wnrs_in_t;

  typedef struct packed {
    logic signed [LEVEL_W-1:0] smoothed_level;
    logic                      switch_needed;
    logic                      other_switch_allowed;
    logic                      any_ear_wind;
  } wnrs_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_TRIM,
    ST_START,
    ST_DIV,
    ST_DONE
  } wnrs_state_t;

endpackage

// File: src/wind_noise_role_switch_judge.sv
// wind_noise_role_switch_judge: top level of the wind noise role switch judge
// uses wnrs_pkg, wnrs_ram (sample window) and wnrs_div (serial divider)
//
// usage
//   in_*  : one request per event: local sample, peer info or clear all.
//           every request answers with exactly one result on out_*.
//   out_* : result holds smoothed level and the three switch verdicts,
//           computed from the state after the request.
//   cfg_* : cfg_we writes the signed noise gap limit (reset value 10);
//           write only while no request is in flight.
// timing
//   a local sample in call mode walks the window through the ram read
//   port, trims max and min, starts the serial divider and runs it at
//   one quotient bit per cycle over 16 + clog2(WINDOW_DEPTH) bits, then
//   picks up the quotient and goes to the done state for the result.
//   other requests go from acceptance straight to the done state,
//   which loads the output register.
//   one request at a time: in_ready is high only while idle.
// reset and stall
//   rst_n clears all tracking state and restores the gap limit. the
//   result sits in an output register; a stalled out_ready holds it and
//   the next request may be accepted meanwhile.
module wind_noise_role_switch_judge #(
  parameter int WINDOW_DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  wnrs_pkg::wnrs_in_t       in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output wnrs_pkg::wnrs_out_t      out_data,
  input  logic                     cfg_we,
  input  logic signed [15:0]       cfg_wdata
);

  import wnrs_pkg::*;

  localparam int SLOT_W = $clog2(WINDOW_DEPTH);
  localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
  // window sum of full-scale samples fits here with sign
  localparam int SUM_W  = LEVEL_W + $clog2(WINDOW_DEPTH);

  // sequencer and output
  wnrs_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  wnrs_out_t   out_data_r, out_data_nxt;

  // architectural state
  logic [SLOT_W-1:0]         slot_r, slot_nxt;
  logic [CNT_W-1:0]          fill_r, fill_nxt;
  logic                      lrun_r, lrun_nxt;
  logic                      lwind_r, lwind_nxt;
  logic signed [LEVEL_W-1:0] llevel_r, llevel_nxt;
  logic                      prun_r, prun_nxt;
  logic                      pwind_r, pwind_nxt;
  logic signed [LEVEL_W-1:0] plevel_r, plevel_nxt;
  logic signed [LEVEL_W-1:0] gap_limit_r, gap_limit_nxt;

  // per request context
  logic links_r, links_nxt;
  logic worn_r, worn_nxt;
  logic primary_r, primary_nxt;

  // walk and divide datapath
  logic [CNT_W-1:0]          issue_r, issue_nxt;
  logic                      rd_vld_r, rd_vld_nxt;
  logic signed [SUM_W-1:0]   sum_r, sum_nxt;
  logic signed [LEVEL_W-1:0] lo_r, lo_nxt;
  logic signed [LEVEL_W-1:0] hi_r, hi_nxt;
  logic                      neg_r, neg_nxt;

  // ram and divider hookup
  logic                      ram_we;
  logic [LEVEL_W-1:0]        ram_rdata;
  logic signed [LEVEL_W-1:0] rd_val;
  logic                      div_start;
  logic [SUM_W-1:0]          div_dividend;
  logic [CNT_W-1:0]          div_divisor;
  logic                      div_done;
  logic [SUM_W-1:0]          div_quo;
  logic [SUM_W-1:0]          quo_signed;

  logic                      accept;
  logic                      full;
  logic signed [LEVEL_W:0]   gap;
  logic                      gap_large;
  logic                      need;
  logic                      allow;
  logic                      any_wind;

  assign accept = in_valid && in_ready;
  assign full   = (fill_r == CNT_W'(WINDOW_DEPTH));
  assign rd_val = signed'(ram_rdata);
  assign ram_we = accept && (in_data.action == ACT_SAMPLE) && in_data.call_mode;

  wnrs_ram #(
    .WIDTH (LEVEL_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_r),
    .wdata (in_data.local_wind_value),
    .raddr (issue_r[SLOT_W-1:0]),
    .rdata (ram_rdata)
  );

  wnrs_div #(
    .DW (SUM_W),
    .VW (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  // divisor drops the trimmed max and min once the window is full
  assign div_divisor  = full ? CNT_W'(WINDOW_DEPTH - 2) : fill_r;
  assign div_dividend = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
  assign quo_signed   = neg_r ? SUM_W'(-div_quo) : div_quo;

  // verdicts from the state after the request
  assign gap       = {plevel_r[LEVEL_W-1], plevel_r} - {llevel_r[LEVEL_W-1], llevel_r};
  assign gap_large = (gap > $signed({gap_limit_r[LEVEL_W-1], gap_limit_r}));
  assign need      = links_r && worn_r && primary_r && lrun_r && prun_r && lwind_r &&
                     (!pwind_r || gap_large);
  assign allow     = !((!lwind_r && pwind_r) || (lwind_r && pwind_r && gap_large));
  assign any_wind  = (pwind_r && prun_r) || (lwind_r && lrun_r);

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    slot_nxt      = slot_r;
    fill_nxt      = fill_r;
    lrun_nxt      = lrun_r;
    lwind_nxt     = lwind_r;
    llevel_nxt    = llevel_r;
    prun_nxt      = prun_r;
    pwind_nxt     = pwind_r;
    plevel_nxt    = plevel_r;
    gap_limit_nxt = gap_limit_r;
    links_nxt     = links_r;
    worn_nxt      = worn_r;
    primary_nxt   = primary_r;
    issue_nxt     = issue_r;
    rd_vld_nxt    = 1'b0;
    sum_nxt       = sum_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    neg_nxt       = neg_r;
    div_start     = 1'b0;

    if (cfg_we) begin
      gap_limit_nxt = cfg_wdata;
    end

    // consumer took the result
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          links_nxt   = in_data.links_up;
          worn_nxt    = in_data.both_in_ear;
          primary_nxt = in_data.is_primary;
          state_nxt   = ST_DONE;
          case (in_data.action)
            ACT_SAMPLE: begin
              if (in_data.call_mode) begin
                lrun_nxt  = 1'b1;
                lwind_nxt = in_data.local_wind_flag;
                slot_nxt  = (slot_r == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : slot_r + 1'b1;
                if (!full) begin
                  fill_nxt = fill_r + 1'b1;
                end
                issue_nxt = '0;
                sum_nxt   = '0;
                lo_nxt    = LEVEL_MAX;
                hi_nxt    = LEVEL_MIN;
                state_nxt = ST_WALK;
              end else begin
                // leaving call mode drops all tracking
                slot_nxt   = '0;
                fill_nxt   = '0;
                lrun_nxt   = 1'b0;
                lwind_nxt  = 1'b0;
                llevel_nxt = '0;
                prun_nxt   = 1'b0;
                pwind_nxt  = 1'b0;
                plevel_nxt = '0;
              end
            end
            ACT_PEER: begin
              // a peer message with a bad length is ignored
              if (in_data.peer_length_ok) begin
                prun_nxt   = in_data.peer_run;
                pwind_nxt  = in_data.peer_wind_flag;
                plevel_nxt = in_data.peer_wind_level;
              end
            end
            ACT_CLEAR: begin
              slot_nxt   = '0;
              fill_nxt   = '0;
              lrun_nxt   = 1'b0;
              lwind_nxt  = 1'b0;
              llevel_nxt = '0;
              prun_nxt   = 1'b0;
              pwind_nxt  = 1'b0;
              plevel_nxt = '0;
            end
            default: begin
              // unused code only answers with the current verdicts
            end
          endcase
        end
      end
      ST_WALK: begin
        // each read is accumulated in the cycle after it issues, via the ram register
        if (issue_r != fill_r) begin
          issue_nxt  = issue_r + 1'b1;
          rd_vld_nxt = 1'b1;
        end
        if (rd_vld_r) begin
          sum_nxt = sum_r + SUM_W'(rd_val);
          if (rd_val < lo_r) begin
            lo_nxt = rd_val;
          end
          if (rd_val > hi_r) begin
            hi_nxt = rd_val;
          end
        end
        if ((issue_r == fill_r) && !rd_vld_r) begin
          state_nxt = ST_TRIM;
        end
      end
      ST_TRIM: begin
        if (full) begin
          sum_nxt = sum_r - SUM_W'(hi_r) - SUM_W'(lo_r);
        end
        state_nxt = ST_START;
      end
      ST_START: begin
        neg_nxt   = sum_r[SUM_W-1];
        div_start = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          llevel_nxt = signed'(quo_signed[LEVEL_W-1:0]);
          state_nxt  = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt                     = 1'b1;
          out_data_nxt.smoothed_level       = llevel_r;
          out_data_nxt.switch_needed        = need;
          out_data_nxt.other_switch_allowed = allow;
          out_data_nxt.any_ear_wind         = any_wind;
          state_nxt                         = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      slot_r      <= '0;
      fill_r      <= '0;
      lrun_r      <= 1'b0;
      lwind_r     <= 1'b0;
      llevel_r    <= '0;
      prun_r      <= 1'b0;
      pwind_r     <= 1'b0;
      plevel_r    <= '0;
      gap_limit_r <= GAP_LIMIT_RST;
      issue_r     <= '0;
      rd_vld_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      slot_r      <= slot_nxt;
      fill_r      <= fill_nxt;
      lrun_r      <= lrun_nxt;
      lwind_r     <= lwind_nxt;
      llevel_r    <= llevel_nxt;
      prun_r      <= prun_nxt;
      pwind_r     <= pwind_nxt;
      plevel_r    <= plevel_nxt;
      gap_limit_r <= gap_limit_nxt;
      issue_r     <= issue_nxt;
      rd_vld_r    <= rd_vld_nxt;
    end
    out_data_r <= out_data_nxt;
    links_r    <= links_nxt;
    worn_r     <= worn_nxt;
    primary_r  <= primary_nxt;
    sum_r      <= sum_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    neg_r      <= neg_nxt;
  end

endmodule

// File: src/wnrs_ram.sv
// wnrs_ram: generic single write port ram with registered read
// one write and one read address per cycle
// no dependencies
module wnrs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: src/wnrs_div.sv
// wnrs_div: unsigned restoring divider, one quotient bit per cycle
// start loads operands, done pulses when the quotient is ready
// no dependencies
module wnrs_div #(
  parameter int DW = 19,
  parameter int VW = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CW = $clog2(DW + 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [VW:0]   rem_r, rem_nxt;
  logic [DW-1:0] quo_r, quo_nxt;
  logic [VW-1:0] dvs_r, dvs_nxt;
  logic [VW:0]   trial;
  logic [VW:0]   diff;
  logic          ge;

  always_comb begin
    trial    = {rem_r[VW-1:0], quo_r[DW-1]};
    ge       = (trial >= {1'b0, dvs_r});
    diff     = trial - {1'b0, dvs_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? diff : trial;
      quo_nxt = {quo_r[DW-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(DW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking bench for wind_noise_role_switch_judge
// random idling on both handshakes, results checked against an in-bench model
// depends on wnrs_pkg and the judge rtl only
module tb_top;
  import wnrs_pkg::*;

  // the package has no name for the spare action code
  localparam logic [1:0] ACT_SPARE = 2'd3;

  localparam int WIN_DEPTH   = 8;
  // covers the slowest request, a local sample over a full window, with margin
  localparam int SETTLE_CYC  = 48;
  // longest quiet stretch: config pause, or a long send gap plus a long
  // result stall plus one smoothing pass; a few times that
  localparam int QUIET_LIMIT = 1500;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 205;

  localparam int SIDE_IN  = 0;
  localparam int SIDE_OUT = 1;

  // how random wind levels are spread within a phase
  localparam int SPREAD_NARROW = 0;
  localparam int SPREAD_WIDE   = 1;
  localparam int SPREAD_EDGE   = 2;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  wnrs_in_t           in_data   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  wnrs_out_t          out_data;
  logic               cfg_we    = 1'b0;
  logic signed [15:0] cfg_wdata = '0;

  // requests waiting to be sent, verdicts waiting to come back
  wnrs_in_t  req_q[$];
  wnrs_out_t verdict_q[$];

  // model state: local sample window, partner report and the gap limit
  int win_ring[WIN_DEPTH];
  int ring_slot;
  int ring_fill;
  bit loc_run;
  bit loc_wind;
  int loc_level;
  bit far_run;
  bit far_wind;
  int far_level;
  int gap_limit = GAP_LIMIT_RST;

  int fail_count;
  int n_req;
  int n_checked;
  int n_trimmed;
  int n_switch;
  int in_gap;
  int out_stall;
  int quiet;
  int calm_left[2];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  wind_noise_role_switch_judge #(
    .WINDOW_DEPTH(WIN_DEPTH)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // judge model
  // ---------------------------------------------------------------------------

  function automatic void clear_judge();
    foreach (win_ring[i]) win_ring[i] = 0;
    ring_slot = 0;
    ring_fill = 0;
    loc_run   = 1'b0;
    loc_wind  = 1'b0;
    loc_level = 0;
    far_run   = 1'b0;
    far_wind  = 1'b0;
    far_level = 0;
  endfunction

  // plain mean while filling, trimmed mean once the window is full;
  // int division truncates toward zero, and the int sum cannot wrap
  function automatic int window_level();
    int sum;
    int lo;
    int hi;
    if (ring_fill == 0) return 0;
    sum = 0;
    lo  = 32767;
    hi  = -32768;
    for (int i = 0; i < ring_fill; i++) begin
      sum += win_ring[i];
      if (win_ring[i] < lo) lo = win_ring[i];
      if (win_ring[i] > hi) hi = win_ring[i];
    end
    if (ring_fill < WIN_DEPTH) return sum / ring_fill;
    return (sum - hi - lo) / (ring_fill - 2);
  endfunction

  // applies one accepted request to the model and returns its verdict
  function automatic wnrs_out_t judge_request(input wnrs_in_t r);
    wnrs_out_t res;
    bit        gap_big;
    case (r.action)
      ACT_SAMPLE: begin
        if (!r.call_mode) begin
          // leaving the call drops all tracking
          clear_judge();
        end else begin
          loc_run  = 1'b1;
          loc_wind = r.local_wind_flag;
          win_ring[ring_slot] = $signed(r.local_wind_value);
          ring_slot = (ring_slot + 1) % WIN_DEPTH;
          if (ring_fill < WIN_DEPTH) ring_fill++;
          if (ring_fill == WIN_DEPTH) n_trimmed++;
          loc_level = window_level();
        end
      end
      ACT_PEER: begin
        // a report of the wrong length is dropped, verdict still given
        if (r.peer_length_ok) begin
          far_run   = r.peer_run;
          far_wind  = r.peer_wind_flag;
          far_level = $signed(r.peer_wind_level);
        end
      end
      ACT_CLEAR: clear_judge();
      default: ;
    endcase
    // the gap is taken at full int width so it never wraps
    gap_big = (far_level - loc_level) > gap_limit;
    res.smoothed_level       = loc_level[15:0];
    res.switch_needed        = r.links_up && r.both_in_ear && r.is_primary && loc_run &&
                               far_run && loc_wind && (!far_wind || gap_big);
    res.other_switch_allowed = !((!loc_wind && far_wind) || (loc_wind && far_wind && gap_big));
    res.any_ear_wind         = (far_wind && far_run) || (loc_wind && loc_run);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // request builders
  // ---------------------------------------------------------------------------

  // random save the context flags (set high), so unused fields toggle too
  function automatic wnrs_in_t noise_req();
    logic [63:0] raw;
    wnrs_in_t    r;
    raw = {$urandom, $urandom};
    r   = raw[$bits(wnrs_in_t)-1:0];
    r.links_up    = 1'b1;
    r.both_in_ear = 1'b1;
    r.is_primary  = 1'b1;
    return r;
  endfunction

  function automatic wnrs_in_t sample_req(input logic cm, input logic wf,
                                          input logic signed [15:0] v);
    wnrs_in_t r;
    r = noise_req();
    r.action           = ACT_SAMPLE;
    r.call_mode        = cm;
    r.local_wind_flag  = wf;
    r.local_wind_value = v;
    return r;
  endfunction

  function automatic wnrs_in_t peer_req(input logic ok, input logic run, input logic wf,
                                        input logic signed [15:0] v);
    wnrs_in_t r;
    r = noise_req();
    r.action          = ACT_PEER;
    r.peer_length_ok  = ok;
    r.peer_run        = run;
    r.peer_wind_flag  = wf;
    r.peer_wind_level = v;
    return r;
  endfunction

  function automatic wnrs_in_t action_req(input logic [1:0] act);
    wnrs_in_t r;
    r = noise_req();
    r.action = act;
    return r;
  endfunction

  function automatic logic signed [15:0] pick_level(input int spread);
    int r;
    r = $urandom_range(0, 99);
    // a quarter of levels are full range whatever the phase asks
    if (r < 25 || spread == SPREAD_WIDE) return 16'($urandom);
    if (spread == SPREAD_NARROW) return 16'(int'($urandom_range(0, 120)) - 60);
    case ($urandom_range(0, 5))
      0: return LEVEL_MAX;
      1: return LEVEL_MIN;
      2: return 16'sd0;
      3: return 16'sd1;
      4: return -16'sd1;
      default: return 16'($urandom);
    endcase
  endfunction

  // mostly in-call samples and good peer reports so the window fills and
  // the verdicts get exercised; clears and junk are kept rare
  function automatic wnrs_in_t random_req(input int spread);
    wnrs_in_t r;
    int       pick;
    pick = $urandom_range(0, 99);
    if (pick < 64) begin
      r = sample_req(1'b1, $urandom_range(0, 9) < 7, pick_level(spread));
    end else if (pick < 66) begin
      r = sample_req(1'b0, 1'($urandom_range(0, 1)), pick_level(spread));
    end else if (pick < 90) begin
      r = peer_req($urandom_range(0, 9) != 0, $urandom_range(0, 7) != 0,
                   1'($urandom_range(0, 1)), pick_level(spread));
    end else if (pick < 93) begin
      r = action_req(ACT_CLEAR);
    end else if (pick < 95) begin
      r = action_req(ACT_SPARE);
    end else begin
      r = noise_req();
    end
    r.links_up    = $urandom_range(0, 9) != 0;
    r.both_in_ear = $urandom_range(0, 9) != 0;
    r.is_primary  = $urandom_range(0, 9) != 0;
    return r;
  endfunction

  // idle length for one side: mostly none or short, a few long, and now
  // and then a calm stretch with no idling at all
  function automatic int idle_cycles(input int side);
    int r;
    if (calm_left[side] > 0) begin
      calm_left[side]--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) calm_left[side] = $urandom_range(10, 40);
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch on result %0d: %s got %0d expected %0d", n_checked, what, got, want);
    fail_count++;
  endtask

  // ---------------------------------------------------------------------------
  // request driver: presents queued requests, predicts each one as it is taken
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : drive_requests
    bit taken;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else begin
      taken = in_valid && in_ready;
      if (taken) begin
        verdict_q.push_back(judge_request(in_data));
        n_req++;
        in_gap = idle_cycles(SIDE_IN);
      end
      if (in_valid && !taken) begin
        // hold valid and payload until the request is taken
      end else if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (req_q.size() != 0) begin
        in_data  <= req_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor: random back-pressure, compares against the oldest verdict
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : collect_results
    wnrs_out_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_stall = 0;
    end else begin
      if (out_valid && out_ready) begin
        n_checked++;
        if (verdict_q.size() == 0) begin
          report_mismatch("result with no request pending", $signed(out_data.smoothed_level), 0);
        end else begin
          want = verdict_q.pop_front();
          if (out_data.smoothed_level !== want.smoothed_level)
            report_mismatch("smoothed_level", $signed(out_data.smoothed_level),
                            $signed(want.smoothed_level));
          if (out_data.switch_needed !== want.switch_needed)
            report_mismatch("switch_needed", out_data.switch_needed, want.switch_needed);
          if (out_data.other_switch_allowed !== want.other_switch_allowed)
            report_mismatch("other_switch_allowed", out_data.other_switch_allowed,
                            want.other_switch_allowed);
          if (out_data.any_ear_wind !== want.any_ear_wind)
            report_mismatch("any_ear_wind", out_data.any_ear_wind, want.any_ear_wind);
          if (want.switch_needed) n_switch++;
        end
        out_stall = idle_cycles(SIDE_OUT);
      end else if (out_stall == 0 && $urandom_range(0, 11) == 0) begin
        // stalls also start while nothing is offered
        out_stall = idle_cycles(SIDE_OUT);
      end
      if (out_stall > 0) begin
        out_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog: ends the run when neither side has moved for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  // checked at the falling edge so queue and valid updates have settled
  task automatic drain_and_settle();
    do @(negedge clk); while (req_q.size() != 0 || in_valid || verdict_q.size() != 0);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic set_gap_limit(input int v);
    drain_and_settle();
    @(posedge clk);
    cfg_wdata <= 16'(v);
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
    gap_limit = v;
  endtask

  initial begin : stimulus
    int limits[PHASES];
    int spreads[PHASES];

    clear_judge();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed part, gap limit at its reset value
    req_q.push_back(peer_req(1'b0, 1'b1, 1'b1, LEVEL_MAX));   // bad length: ignored
    req_q.push_back(action_req(ACT_SPARE));                    // spare code: no change
    req_q.push_back(sample_req(1'b1, 1'b1, LEVEL_MAX));
    req_q.push_back(sample_req(1'b1, 1'b1, LEVEL_MIN));        // mean of -1/2 truncates to 0
    req_q.push_back(peer_req(1'b1, 1'b1, 1'b0, LEVEL_MIN));    // calm partner: switch advised
    // fill the window with extremes: wide sum, then the trimmed mean
    repeat (6) req_q.push_back(sample_req(1'b1, 1'b1, LEVEL_MAX));
    req_q.push_back(sample_req(1'b1, 1'b1, LEVEL_MIN));        // write slot wraps
    req_q.push_back(peer_req(1'b1, 1'b1, 1'b1, LEVEL_MAX));
    req_q.push_back(action_req(ACT_CLEAR));
    req_q.push_back(sample_req(1'b1, 1'b1, -16'sd7));
    req_q.push_back(sample_req(1'b1, 1'b1, -16'sd2));          // -4.5 truncates to -4
    // gap right at the limit and one past it, both sides windy
    req_q.push_back(action_req(ACT_CLEAR));
    req_q.push_back(sample_req(1'b1, 1'b1, 16'sd500));
    req_q.push_back(peer_req(1'b1, 1'b1, 1'b1, 16'sd510));
    req_q.push_back(peer_req(1'b1, 1'b1, 1'b1, 16'sd511));
    req_q.push_back(sample_req(1'b1, 1'b0, 16'sd500));         // only the partner windy
    req_q.push_back(sample_req(1'b0, 1'b1, LEVEL_MAX));        // call ended: clears
    req_q.push_back(peer_req(1'b1, 1'b0, 1'b1, 16'sd0));       // windy but not running
    req_q.push_back(sample_req(1'b1, 1'b1, 16'sd0));
    req_q[$].links_up = 1'b0;

    // random phases, each under its own gap limit, extremes among them
    limits[0]  = 0;
    limits[1]  = LEVEL_MAX;
    limits[2]  = LEVEL_MIN;
    limits[3]  = -1;
    limits[4]  = int'($urandom_range(0, 80)) - 40;
    limits[5]  = $signed(16'($urandom));
    spreads[0] = SPREAD_NARROW;
    spreads[1] = SPREAD_EDGE;
    spreads[2] = SPREAD_WIDE;
    spreads[3] = SPREAD_NARROW;
    spreads[4] = SPREAD_NARROW;
    spreads[5] = SPREAD_WIDE;
    for (int p = 0; p < PHASES; p++) begin
      set_gap_limit(limits[p]);
      for (int k = 0; k < PHASE_ITEMS; k++) req_q.push_back(random_req(spreads[p]));
    end

    drain_and_settle();
    $display("ran %0d requests, checked %0d results, %0d with a full trimmed window",
             n_req, n_checked, n_trimmed);
    $display("%0d switch advisories seen over the reset gap limit and %0d written ones",
             n_switch, PHASES);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/wnrs_pkg.sv
src/wnrs_ram.sv
src/wnrs_div.sv
src/wind_noise_role_switch_judge.sv
tb/tb_top.sv
